// ----- sv/newell_normal_projection_plane_macros.svh -----
// Assertion macros shared by the checker of the Newell normal block.
`ifndef NEWELL_NORMAL_PROJECTION_PLANE_MACROS_SVH
`define NEWELL_NORMAL_PROJECTION_PLANE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define NNPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nnpp assertion failed");

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define NNPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nnpp assertion failed");

`endif

// ----- sv/nnpp_pkg.sv -----
// Package with the types and fixed widths of the Newell normal block.
`default_nettype none

package nnpp_pkg;

    // Port widths of the vertex, normal and tolerance fields.
    localparam int VERT_W  = 24;
    localparam int NORM_W  = 61;
    localparam int TOL_W   = 64;
    localparam int PLANE_W = 2;

    // Projection plane codes.
    typedef enum logic [PLANE_W-1:0] {
        PLANE_YZ = 2'd0,
        PLANE_XZ = 2'd1,
        PLANE_XY = 2'd2
    } t_plane;

endpackage

`default_nettype wire

// ----- sv/newell_normal_projection_plane.sv -----
// Newell polygon normal accumulator with degenerate test and projection plane choice.
//
//  Channel   Signals                                  Direction  Transfer
//  vertex    i_vert_valid/o_vert_ready, x y z, last   in         one vertex
//  config    i_cfg_valid/o_cfg_ready, tolerance       in         one register write
//  result    o_res_valid/i_res_ready, plane, flags    out        one ring result
//
// One vertex is taken per cycle while o_vert_ready is high. The result of a closing vertex
// passes through the six-register pipeline (input, products, accumulator, magnitudes,
// squares, result) before it is offered. Reset is synchronous and clears the accumulator,
// the vertex count and all valid flags. A stalled result holds the result register;
// earlier stages keep filling until every stage is occupied.
`default_nettype none

module newell_normal_projection_plane #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Vertex channel
    input  wire logic                           i_vert_valid,
    output logic                                o_vert_ready,
    input  wire logic [nnpp_pkg::VERT_W-1:0]    i_vert_x,
    input  wire logic [nnpp_pkg::VERT_W-1:0]    i_vert_y,
    input  wire logic [nnpp_pkg::VERT_W-1:0]    i_vert_z,
    input  wire logic                           i_last_vertex,
    // Configuration channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [nnpp_pkg::TOL_W-1:0]     i_degenerate_tol_sq,
    // Result channel
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output logic [nnpp_pkg::PLANE_W-1:0]        o_plane,
    output logic                                o_degenerate,
    output logic [nnpp_pkg::NORM_W-1:0]         o_normal_x,
    output logic [nnpp_pkg::NORM_W-1:0]         o_normal_y,
    output logic [nnpp_pkg::NORM_W-1:0]         o_normal_z
);
    import nnpp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W  = COORD_BITS + 1;
    localparam int PROD_W = 2 * SUM_W;
    localparam int HALF_W = 32;
    localparam int SQ_W   = 2 * HALF_W;
    localparam int ACC_W  = SQ_W + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]     t_prod;

    // Ring state kept at the input side.
    t_coord            r_first [3];
    t_coord            r_prev  [3];
    logic [CNT_W-1:0]  r_count;
    logic [TOL_W-1:0]  r_tol;

    // Stage 1: captured vertex with its neighbors.
    logic              r_s1_valid, r_s1_last, r_s1_edge;
    t_coord            r_s1_cur [3];
    t_coord            r_s1_prv [3];
    t_coord            r_s1_fst [3];

    // Stage 2: edge and closing products.
    logic              r_s2_valid, r_s2_last;
    t_prod             r_s2_te [3];
    t_prod             r_s2_tc [3];

    // Stage 3: accumulator and finished normal.
    logic [NORM_W-1:0] r_acc [3];
    logic              r_s3_valid;
    logic [NORM_W-1:0] r_s3_norm [3];

    // Stage 4: magnitudes.
    logic              r_s4_valid;
    logic [NORM_W-1:0] r_s4_mag  [3];
    logic [NORM_W-1:0] r_s4_norm [3];

    // Stage 5: squares and plane choice.
    logic              r_s5_valid, r_s5_big;
    logic [SQ_W-1:0]   r_s5_sq   [3];
    t_plane            r_s5_plane;
    logic [NORM_W-1:0] r_s5_norm [3];

    // Stage 6: result register.
    logic              r_s6_valid, r_s6_degen;
    t_plane            r_s6_plane;
    logic [NORM_W-1:0] r_s6_norm [3];

    logic   rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic   vert_xfer;
    t_coord cur [3];
    t_prod  n_te [3];
    t_prod  n_tc [3];
    logic [NORM_W-1:0] n_acc_sum [3];
    logic [NORM_W-1:0] n_mag [3];
    logic              n_big;
    t_plane            n_plane;
    logic [ACC_W-1:0]  n_sq_sum;
    logic              n_degen;

    // A stage moves when it is empty or its successor moves.
    assign rdy6 = !r_s6_valid || i_res_ready;
    assign rdy5 = !r_s5_valid || rdy6;
    assign rdy4 = !r_s4_valid || rdy5;
    assign rdy3 = !r_s3_valid || rdy4;
    assign rdy2 = !r_s2_valid || rdy3;
    assign rdy1 = !r_s1_valid || rdy2;

    assign o_vert_ready = rdy1;
    assign vert_xfer    = i_vert_valid && rdy1;
    assign o_cfg_ready  = 1'b1;

    // Low COORD_BITS of each coordinate, taken as two's complement.
    assign cur[0] = $signed(i_vert_x[COORD_BITS-1:0]);
    assign cur[1] = $signed(i_vert_y[COORD_BITS-1:0]);
    assign cur[2] = $signed(i_vert_z[COORD_BITS-1:0]);

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_degenerate_tol_sq;
        end
    end

    // Ring bookkeeping and stage 1 capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_vert_valid;
            end
            if (vert_xfer) begin
                if (i_last_vertex) begin
                    r_count <= '0;
                end else if (r_count != CNT_W'(MAX_VERTICES)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vert_xfer) begin
            r_s1_last <= i_last_vertex;
            r_s1_edge <= (r_count != '0);
            for (int k = 0; k < 3; k++) begin
                r_prev[k]   <= cur[k];
                r_s1_cur[k] <= cur[k];
                r_s1_prv[k] <= r_prev[k];
                r_s1_fst[k] <= (r_count == '0) ? cur[k] : r_first[k];
                if (r_count == '0) begin
                    r_first[k] <= cur[k];
                end
            end
        end
    end

    // Newell products for the edge into this vertex and the closing edge.
    always_comb begin
        logic signed [SUM_W-1:0] ea [3];
        logic signed [SUM_W-1:0] ed [3];
        logic signed [SUM_W-1:0] ca [3];
        logic signed [SUM_W-1:0] cd [3];
        for (int k = 0; k < 3; k++) begin
            ea[k] = SUM_W'(r_s1_prv[k]) + SUM_W'(r_s1_cur[k]);
            ed[k] = SUM_W'(r_s1_prv[k]) - SUM_W'(r_s1_cur[k]);
            ca[k] = SUM_W'(r_s1_cur[k]) + SUM_W'(r_s1_fst[k]);
            cd[k] = SUM_W'(r_s1_cur[k]) - SUM_W'(r_s1_fst[k]);
        end
        n_te[0] = PROD_W'(ea[2]) * PROD_W'(ed[1]);
        n_te[1] = PROD_W'(ea[0]) * PROD_W'(ed[2]);
        n_te[2] = PROD_W'(ea[1]) * PROD_W'(ed[0]);
        n_tc[0] = PROD_W'(ca[2]) * PROD_W'(cd[1]);
        n_tc[1] = PROD_W'(ca[0]) * PROD_W'(cd[2]);
        n_tc[2] = PROD_W'(ca[1]) * PROD_W'(cd[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_s1_valid) begin
            r_s2_last <= r_s1_last;
            for (int k = 0; k < 3; k++) begin
                r_s2_te[k] <= r_s1_edge ? n_te[k] : '0;
                r_s2_tc[k] <= r_s1_last ? n_tc[k] : '0;
            end
        end
    end

    // Accumulate; a closing vertex hands the sum on and clears the accumulator.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_acc_sum[k] = r_acc[k] + NORM_W'(r_s2_te[k]) + NORM_W'(r_s2_tc[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= '0;
            end
        end else if (rdy3) begin
            r_s3_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= r_s2_last ? '0 : n_acc_sum[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid && r_s2_last) begin
            for (int k = 0; k < 3; k++) begin
                r_s3_norm[k] <= n_acc_sum[k];
            end
        end
    end

    // Absolute values of the components.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_s3_norm[k][NORM_W-1] ? (~r_s3_norm[k] + NORM_W'(1)) : r_s3_norm[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (rdy4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_s3_valid) begin
            r_s4_mag  <= n_mag;
            r_s4_norm <= r_s3_norm;
        end
    end

    // Dominant axis, ties going to yz, then xz; also the overflow flag for squaring.
    always_comb begin
        n_big = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_big = n_big || (r_s4_mag[k][NORM_W-1:HALF_W] != '0);
        end
        if (r_s4_mag[0] >= r_s4_mag[1] && r_s4_mag[0] >= r_s4_mag[2]) begin
            n_plane = PLANE_YZ;
        end else if (r_s4_mag[1] >= r_s4_mag[2]) begin
            n_plane = PLANE_XZ;
        end else begin
            n_plane = PLANE_XY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (rdy5) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_s4_valid) begin
            r_s5_big   <= n_big;
            r_s5_plane <= n_plane;
            r_s5_norm  <= r_s4_norm;
            for (int k = 0; k < 3; k++) begin
                r_s5_sq[k] <= SQ_W'(r_s4_mag[k][HALF_W-1:0])
                              * SQ_W'(r_s4_mag[k][HALF_W-1:0]);
            end
        end
    end

    // Squared length against the tolerance; a length of 2^64 or more never counts.
    assign n_sq_sum = ACC_W'(r_s5_sq[0]) + ACC_W'(r_s5_sq[1]) + ACC_W'(r_s5_sq[2]);
    assign n_degen  = !r_s5_big && (n_sq_sum[ACC_W-1:SQ_W] == '0)
                      && (n_sq_sum[SQ_W-1:0] <= r_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (rdy6) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6 && r_s5_valid) begin
            r_s6_degen <= n_degen;
            r_s6_plane <= n_degen ? PLANE_YZ : r_s5_plane;
            r_s6_norm  <= r_s5_norm;
        end
    end

    // Result outputs.
    assign o_res_valid  = r_s6_valid;
    assign o_plane      = r_s6_plane;
    assign o_degenerate = r_s6_degen;
    assign o_normal_x   = r_s6_norm[0];
    assign o_normal_y   = r_s6_norm[1];
    assign o_normal_z   = r_s6_norm[2];

endmodule

`default_nettype wire

// ----- sv/nnpp_checker.sv -----
// Port-level checker for the Newell normal block, with its bind.
`default_nettype none

`include "newell_normal_projection_plane_macros.svh"

module nnpp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_res_valid,
    input wire logic                           i_res_ready,
    input wire logic [nnpp_pkg::PLANE_W-1:0]   o_plane,
    input wire logic                           o_degenerate,
    input wire logic [nnpp_pkg::NORM_W-1:0]    o_normal_x,
    input wire logic [nnpp_pkg::NORM_W-1:0]    o_normal_y,
    input wire logic [nnpp_pkg::NORM_W-1:0]    o_normal_z
);
    import nnpp_pkg::*;

    // A waiting result stays offered, with its x normal and plane unchanged.
    `NNPP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid && $stable(o_normal_x) && $stable(o_plane))

    // A degenerate ring always reports the yz plane.
    `NNPP_ASSERT_NOW(a_degen_plane, i_clk, i_rst_n, o_res_valid && o_degenerate, o_plane == PLANE_YZ)

    // A zero normal is at or below any tolerance.
    `NNPP_ASSERT_NOW(a_zero_degen, i_clk, i_rst_n, o_res_valid && o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0, o_degenerate)

    // The xy plane is only chosen when the z component is strictly dominant, so never zero.
    `NNPP_ASSERT_NOW(a_xy_nonzero, i_clk, i_rst_n, o_res_valid && !o_degenerate && o_plane == PLANE_XY, o_normal_z != '0)

endmodule

bind newell_normal_projection_plane nnpp_checker u_nnpp_checker (.*);

`default_nettype wire
